// File: rtl/ssi_pkg.sv
`default_nettype none
package ssi_pkg;

  typedef enum logic [1:0] {
    ST_PARALLEL = 2'd0,
    ST_SKEW     = 2'd1,
    ST_INSIDE   = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  localparam int PARAM_W = 32;
  localparam int MEET_W  = 40;

endpackage
`default_nettype wire

// File: rtl/ssi_front.sv
`default_nettype none
module ssi_front #(
  parameter int CB = 16,
  localparam int DW = 2 * CB + 3,
  localparam int NW = 2 * DW + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [12*CB-1:0]      in_data_i,
  output ssi_pkg::status_e           out_status_o,
  output logic                       out_valid_o,
  output logic                       out_tneg_o,
  output logic                       out_sneg_o,
  output logic [NW-1:0]              out_den_o,
  output logic [NW-1:0]              out_tmag_o,
  output logic [NW-1:0]              out_smag_o,
  output logic [3*CB-1:0]            out_ps_o,
  output logic [3*(CB+1)-1:0]        out_u_o
);

  localparam int PW = 2 * DW;
  localparam int TW = 3 * CB + 6;
  localparam int QW = 2 * CB + 2;

  logic signed [CB-1:0] p [12];
  logic [5:1] vld_q;

  // stage 1: differences
  logic signed [CB:0]   u1_q [3], v1_q [3], w1_q [3];
  logic signed [CB-1:0] ps1_q [3];
  // stage 2: dot and cross products
  logic signed [DW-1:0] a2_q, b2_q, c2_q, d2_q, e2_q;
  logic signed [DW-1:0] cr2_q [3];
  logic signed [CB:0]   u2_q [3], w2_q [3];
  logic signed [CB-1:0] ps2_q [3];
  // stage 3: wide products
  logic signed [PW-1:0] ac3_q, bb3_q, be3_q, cd3_q, ae3_q, bd3_q;
  logic signed [TW-1:0] tp3_q [3];
  logic signed [CB:0]   u3_q [3];
  logic signed [CB-1:0] ps3_q [3];
  // stage 4: determinants
  logic signed [NW-1:0] den4_q, tn4_q, sn4_q;
  logic signed [TW-1:0] trip4_q;
  logic signed [CB:0]   u4_q [3];
  logic signed [CB-1:0] ps4_q [3];
  // stage 5: classification
  ssi_pkg::status_e     st5_q;
  logic                 tneg5_q, sneg5_q;
  logic [NW-1:0]        den5_q, tmag5_q, smag5_q;
  logic signed [CB:0]   u5_q [3];
  logic signed [CB-1:0] ps5_q [3];

  logic signed [QW-1:0] uu [3], uv [3], vv [3], uw [3], vw [3];
  logic signed [QW-1:0] cp [6];
  ssi_pkg::status_e     st_d;
  logic                 tin, sin;

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      p[i] = signed'(in_data_i[i*CB +: CB]);
    end
    for (int i = 0; i < 3; i++) begin
      uu[i] = u1_q[i] * u1_q[i];
      uv[i] = u1_q[i] * v1_q[i];
      vv[i] = v1_q[i] * v1_q[i];
      uw[i] = u1_q[i] * w1_q[i];
      vw[i] = v1_q[i] * w1_q[i];
    end
    cp[0] = u1_q[1] * v1_q[2];
    cp[1] = u1_q[2] * v1_q[1];
    cp[2] = u1_q[2] * v1_q[0];
    cp[3] = u1_q[0] * v1_q[2];
    cp[4] = u1_q[0] * v1_q[1];
    cp[5] = u1_q[1] * v1_q[0];
  end

  always_comb begin
    tin = !tn4_q[NW-1] && (tn4_q <= den4_q);
    sin = !sn4_q[NW-1] && (sn4_q <= den4_q);
    if (den4_q == '0) begin
      st_d = ssi_pkg::ST_PARALLEL;
    end else if (trip4_q != '0) begin
      st_d = ssi_pkg::ST_SKEW;
    end else if (tin && sin) begin
      st_d = ssi_pkg::ST_INSIDE;
    end else begin
      st_d = ssi_pkg::ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      u1_q[i]  <= {p[3+i][CB-1], p[3+i]} - {p[i][CB-1], p[i]};
      v1_q[i]  <= {p[9+i][CB-1], p[9+i]} - {p[6+i][CB-1], p[6+i]};
      w1_q[i]  <= {p[i][CB-1], p[i]} - {p[6+i][CB-1], p[6+i]};
      ps1_q[i] <= p[i];
      u2_q[i]  <= u1_q[i];
      w2_q[i]  <= w1_q[i];
      ps2_q[i] <= ps1_q[i];
      tp3_q[i] <= w2_q[i] * cr2_q[i];
      u3_q[i]  <= u2_q[i];
      ps3_q[i] <= ps2_q[i];
      u4_q[i]  <= u3_q[i];
      ps4_q[i] <= ps3_q[i];
      u5_q[i]  <= u4_q[i];
      ps5_q[i] <= ps4_q[i];
    end
    a2_q <= DW'(uu[0]) + DW'(uu[1]) + DW'(uu[2]);
    b2_q <= DW'(uv[0]) + DW'(uv[1]) + DW'(uv[2]);
    c2_q <= DW'(vv[0]) + DW'(vv[1]) + DW'(vv[2]);
    d2_q <= DW'(uw[0]) + DW'(uw[1]) + DW'(uw[2]);
    e2_q <= DW'(vw[0]) + DW'(vw[1]) + DW'(vw[2]);
    cr2_q[0] <= DW'(cp[0]) - DW'(cp[1]);
    cr2_q[1] <= DW'(cp[2]) - DW'(cp[3]);
    cr2_q[2] <= DW'(cp[4]) - DW'(cp[5]);

    ac3_q <= a2_q * c2_q;
    bb3_q <= b2_q * b2_q;
    be3_q <= b2_q * e2_q;
    cd3_q <= c2_q * d2_q;
    ae3_q <= a2_q * e2_q;
    bd3_q <= b2_q * d2_q;

    den4_q  <= NW'(ac3_q) - NW'(bb3_q);
    tn4_q   <= NW'(be3_q) - NW'(cd3_q);
    sn4_q   <= NW'(ae3_q) - NW'(bd3_q);
    trip4_q <= tp3_q[0] + tp3_q[1] + tp3_q[2];

    st5_q   <= st_d;
    tneg5_q <= tn4_q[NW-1];
    sneg5_q <= sn4_q[NW-1];
    den5_q  <= den4_q;
    tmag5_q <= tn4_q[NW-1] ? NW'(-tn4_q) : NW'(tn4_q);
    smag5_q <= sn4_q[NW-1] ? NW'(-sn4_q) : NW'(sn4_q);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_ps_o[i*CB +: CB]         = ps5_q[i];
      out_u_o[i*(CB+1) +: (CB+1)] = u5_q[i];
    end
  end

  assign out_valid_o  = vld_q[5];
  assign out_status_o = st5_q;
  assign out_tneg_o   = tneg5_q;
  assign out_sneg_o   = sneg5_q;
  assign out_den_o    = den5_q;
  assign out_tmag_o   = tmag5_q;
  assign out_smag_o   = smag5_q;

endmodule
`default_nettype wire

// File: rtl/ssi_fifo.sv
`default_nettype none
module ssi_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

endmodule
`default_nettype wire

// File: rtl/ssi_back.sv
`default_nettype none
module ssi_back #(
  parameter int CB = 16,
  parameter int FB = 16,
  localparam int DW = 2 * CB + 3,
  localparam int NW = 2 * DW + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_pop_o,
  input  ssi_pkg::status_e           in_status_i,
  input  wire logic                  in_tneg_i,
  input  wire logic                  in_sneg_i,
  input  wire logic [NW-1:0]         in_den_i,
  input  wire logic [NW-1:0]         in_tmag_i,
  input  wire logic [NW-1:0]         in_smag_i,
  input  wire logic [3*CB-1:0]       in_ps_i,
  input  wire logic [3*(CB+1)-1:0]   in_u_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output ssi_pkg::status_e           out_status_o,
  output logic [ssi_pkg::PARAM_W-1:0] out_t_o,
  output logic [ssi_pkg::PARAM_W-1:0] out_s_o,
  output logic [3*ssi_pkg::MEET_W-1:0] out_meet_o
);

  localparam int QB  = ssi_pkg::PARAM_W;
  localparam int RW  = NW + FB + QB + 1;
  localparam int PRW = QB + CB + 1;
  localparam int BW  = CB + FB;
  localparam int MB  = (PRW > BW ? PRW : BW) + 1;
  localparam int MX  = (MB > ssi_pkg::MEET_W + 1) ? MB : ssi_pkg::MEET_W + 1;
  localparam int MW  = ssi_pkg::MEET_W;
  localparam logic signed [MX-1:0] LIM_HI = MX'(64'sh7F_FFFF_FFFF);
  localparam logic signed [MX-1:0] LIM_LO = -LIM_HI - MX'(1);

  typedef struct packed {
    ssi_pkg::status_e      status;
    logic                  tneg;
    logic                  sneg;
    logic                  tbig;
    logic                  sbig;
    logic [2:0][CB-1:0]    ps;
    logic [2:0][CB:0]      u;
  } side_t;

  logic            adv;
  logic [0:QB+2]   vld_q;
  side_t           side_q [QB+2];
  logic [NW-1:0]   den_q [QB+1];
  logic [RW-1:0]   rt_q [QB+1], rs_q [QB+1];
  logic [QB-1:0]   qt_q [QB+1], qs_q [QB+1];

  logic signed [QB-1:0]  t33_q, s33_q;
  ssi_pkg::status_e      st34_q;
  logic signed [QB-1:0]  t34_q, s34_q;
  logic signed [PRW-1:0] pr34_q [3];
  logic signed [BW-1:0]  base34_q [3];

  logic                  out_vld_q;
  ssi_pkg::status_e      out_st_q;
  logic [QB-1:0]         out_t_q, out_s_q;
  logic [MW-1:0]         out_m_q [3];

  side_t         side_in;
  logic [RW-1:0] nt_in, ns_in, dtop_in;
  logic signed [MX-1:0] msum [3];
  logic signed [MX-1:0] msat [3];

  function automatic logic [QB-1:0] sat_q(logic par, logic neg, logic big,
                                          logic [QB-1:0] q);
    logic [QB-1:0] r;
    if (par) begin
      r = '0;
    end else if (neg) begin
      r = (big || q[QB-1]) ? {1'b1, {(QB-1){1'b0}}} : -q;
    end else begin
      r = (big || q[QB-1]) ? {1'b0, {(QB-1){1'b1}}} : q;
    end
    return r;
  endfunction

  assign adv      = !out_vld_q || out_ready_i;
  assign in_pop_o = adv && in_valid_i;

  always_comb begin
    nt_in   = RW'(in_tmag_i) << FB;
    ns_in   = RW'(in_smag_i) << FB;
    dtop_in = RW'(in_den_i) << QB;
    side_in.status = in_status_i;
    side_in.tneg   = in_tneg_i;
    side_in.sneg   = in_sneg_i;
    side_in.tbig   = (nt_in >= dtop_in);
    side_in.sbig   = (ns_in >= dtop_in);
    for (int i = 0; i < 3; i++) begin
      side_in.ps[i] = in_ps_i[i*CB +: CB];
      side_in.u[i]  = in_u_i[i*(CB+1) +: (CB+1)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {in_valid_i, vld_q[0:QB+1]};
      out_vld_q <= vld_q[QB+2];
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      den_q[0]  <= in_den_i;
      rt_q[0]   <= nt_in;
      rs_q[0]   <= ns_in;
      qt_q[0]   <= '0;
      qs_q[0]   <= '0;
      for (int k = 0; k < QB; k++) begin
        side_q[k+1] <= side_q[k];
        den_q[k+1]  <= den_q[k];
        if (rt_q[k] >= (RW'(den_q[k]) << (QB - 1 - k))) begin
          rt_q[k+1] <= rt_q[k] - (RW'(den_q[k]) << (QB - 1 - k));
          qt_q[k+1] <= qt_q[k] | (QB'(1) << (QB - 1 - k));
        end else begin
          rt_q[k+1] <= rt_q[k];
          qt_q[k+1] <= qt_q[k];
        end
        if (rs_q[k] >= (RW'(den_q[k]) << (QB - 1 - k))) begin
          rs_q[k+1] <= rs_q[k] - (RW'(den_q[k]) << (QB - 1 - k));
          qs_q[k+1] <= qs_q[k] | (QB'(1) << (QB - 1 - k));
        end else begin
          rs_q[k+1] <= rs_q[k];
          qs_q[k+1] <= qs_q[k];
        end
      end

      side_q[QB+1] <= side_q[QB];
      t33_q <= sat_q(side_q[QB].status == ssi_pkg::ST_PARALLEL, side_q[QB].tneg,
                     side_q[QB].tbig, qt_q[QB]);
      s33_q <= sat_q(side_q[QB].status == ssi_pkg::ST_PARALLEL, side_q[QB].sneg,
                     side_q[QB].sbig, qs_q[QB]);

      st34_q <= side_q[QB+1].status;
      t34_q  <= t33_q;
      s34_q  <= s33_q;
      for (int i = 0; i < 3; i++) begin
        pr34_q[i]   <= t33_q * signed'(side_q[QB+1].u[i]);
        base34_q[i] <= signed'({side_q[QB+1].ps[i], {FB{1'b0}}});
      end

      out_st_q <= st34_q;
      out_t_q  <= t34_q;
      out_s_q  <= s34_q;
      for (int i = 0; i < 3; i++) begin
        out_m_q[i] <= MW'(msat[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      msum[i] = MX'(pr34_q[i]) + MX'(base34_q[i]);
      if (msum[i] > LIM_HI) begin
        msat[i] = LIM_HI;
      end else if (msum[i] < LIM_LO) begin
        msat[i] = LIM_LO;
      end else begin
        msat[i] = msum[i];
      end
      out_meet_o[i*MW +: MW] = out_m_q[i];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_st_q;
  assign out_t_o      = out_t_q;
  assign out_s_o      = out_s_q;

endmodule
`default_nettype wire

// File: rtl/segment_segment_intersect_3d.sv
// Closest points and intersection of two 3D segments given as signed integer
// endpoints. Each input transfer yields one result: a status (parallel, skew,
// lines meet inside both segments, lines meet outside), the line parameters
// t and s in saturating Q15.16 (zero when parallel) and the closest point on
// the first line in saturating Q23.16. The block takes one segment pair per
// clock cycle while the result side keeps up. Each pair passes through a
// 5-stage front end that forms the dot products and determinants and then
// through the 32-stage restoring divider (one quotient bit per stage).
// An 8-entry queue between the two parts absorbs result-side stalls.
`default_nettype none
module segment_segment_intersect_3d #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // a_start_x/y/z, a_end_x/y/z, b_start_x/y/z, b_end_x/y/z, zero pad
  input  wire logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // status, t_fixed, s_fixed, meet_x, meet_y, meet_z, zero pad
  output logic [191:0]             m_axis_tdata_o
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = 2 * CB + 3;
  localparam int NW    = 2 * DW + 1;
  localparam int DEPTH = 8;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int QW    = 2 + 2 + 3 * NW + 3 * CB + 3 * (CB + 1);
  localparam int MW    = ssi_pkg::MEET_W;
  localparam int PB    = ssi_pkg::PARAM_W;

  logic          in_acc, pop;
  logic [CW-1:0] cnt_q;

  logic                f_valid, f_tneg, f_sneg;
  ssi_pkg::status_e    f_status;
  logic [NW-1:0]       f_den, f_tmag, f_smag;
  logic [3*CB-1:0]     f_ps;
  logic [3*(CB+1)-1:0] f_u;

  logic          q_valid;
  logic [QW-1:0] q_data;
  ssi_pkg::status_e q_status;

  ssi_pkg::status_e  b_status;
  logic [PB-1:0]     b_t, b_s;
  logic [3*MW-1:0]   b_meet;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  // count items in the front pipe and the queue so the queue never overflows
  assign s_axis_tready_o = (cnt_q < CW'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CW'(in_acc) - CW'(pop);
    end
  end

  ssi_front #(.CB(CB)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_acc),
    .in_data_i    (s_axis_tdata_i[12*CB-1:0]),
    .out_status_o (f_status),
    .out_valid_o  (f_valid),
    .out_tneg_o   (f_tneg),
    .out_sneg_o   (f_sneg),
    .out_den_o    (f_den),
    .out_tmag_o   (f_tmag),
    .out_smag_o   (f_smag),
    .out_ps_o     (f_ps),
    .out_u_o      (f_u)
  );

  ssi_fifo #(.W(QW), .DEPTH(DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i ({f_u, f_ps, f_smag, f_tmag, f_den, f_sneg, f_tneg, f_status}),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  assign q_status = ssi_pkg::status_e'(q_data[1:0]);

  ssi_back #(.CB(CB), .FB(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_pop_o     (pop),
    .in_status_i  (q_status),
    .in_tneg_i    (q_data[2]),
    .in_sneg_i    (q_data[3]),
    .in_den_i     (q_data[4 +: NW]),
    .in_tmag_i    (q_data[4+NW +: NW]),
    .in_smag_i    (q_data[4+2*NW +: NW]),
    .in_ps_i      (q_data[4+3*NW +: 3*CB]),
    .in_u_i       (q_data[4+3*NW+3*CB +: 3*(CB+1)]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (b_status),
    .out_t_o      (b_t),
    .out_s_o      (b_s),
    .out_meet_o   (b_meet)
  );

  assign m_axis_tdata_o = {6'd0, b_meet, b_s, b_t, b_status};

endmodule
`default_nettype wire
